FILE: src/icse_pkg.sv
// ----------------------------------------------------------------------------
// icse_pkg: shared types and constants for the integer column store engine
// Request kinds, result codes, relation codes, controller states, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package icse_pkg;

  localparam int MaxRowsDefault = 1024;

  localparam int KindW   = 3;
  localparam int RowW    = 10;
  localparam int ValW    = 32;
  localparam int OpW     = 3;
  localparam int OrdW    = 2;
  localparam int StatW   = 3;
  localparam int TotalW  = 11;
  localparam int InDataW  = 48;
  localparam int OutDataW = 112;
  localparam int AddrW   = 3;

  localparam logic [AddrW-1:0] RegUniqueKey = 3'd0;

  localparam logic [KindW-1:0] KindAppend = 3'd0;
  localparam logic [KindW-1:0] KindUpdate = 3'd1;
  localparam logic [KindW-1:0] KindTest   = 3'd2;
  localparam logic [KindW-1:0] KindAggr   = 3'd3;
  localparam logic [KindW-1:0] KindSort   = 3'd4;

  localparam logic [StatW-1:0] StOk    = 3'd0;
  localparam logic [StatW-1:0] StDup   = 3'd1;
  localparam logic [StatW-1:0] StNoRow = 3'd2;
  localparam logic [StatW-1:0] StBadOp = 3'd3;
  localparam logic [StatW-1:0] StFull  = 3'd4;

  localparam logic [OpW-1:0] OpEq = 3'd0;
  localparam logic [OpW-1:0] OpGt = 3'd1;
  localparam logic [OpW-1:0] OpGe = 3'd2;
  localparam logic [OpW-1:0] OpLt = 3'd3;
  localparam logic [OpW-1:0] OpLe = 3'd4;
  localparam logic [OpW-1:0] OpNe = 3'd5;

  localparam logic [OrdW-1:0] OrdAsc  = 2'd0;
  localparam logic [OrdW-1:0] OrdDesc = 2'd1;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_USE, S_SCAN_CHK, S_APPEND, S_UPDATE,
    S_ROW_RD, S_TEST, S_SORT_START, S_SORT_RD0, S_SORT_LOAD, S_SORT_RD,
    S_SORT_STEP, S_SORT_CHK, S_SORT_LAST, S_RESULT
  } state_t;

  typedef enum logic [3:0] {
    DP_IDLE, DP_LOAD, DP_READ_IDX, DP_READ_ROW, DP_SCAN_STEP, DP_APPEND,
    DP_UPDATE, DP_TEST, DP_SORT_INIT, DP_SORT_FIRST, DP_SORT_STEP,
    DP_SORT_LAST, DP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [StatW-1:0] res;
  } icse_cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             uniq;
    logic             full;
    logic             empty;
    logic             fewer_two;
    logic             row_ok;
    logic             op_ok;
    logic             ord_ok;
    logic             idx_done;
    logic             found;
    logic             swapped;
    logic             out_free;
  } icse_stat_t;

endpackage

FILE: src/integer_column_store_engine.sv
// ----------------------------------------------------------------------------
// integer_column_store_engine: column store with filter and aggregate unit
// Keeps a column of signed 32-bit values and serves one request at a time.
// ----------------------------------------------------------------------------
// Flow: a request is taken in the idle state and dispatched in the next
//   cycle; an append without key check or a plain update then writes the
//   column, a row test reads and compares its row, and a scan (key check or
//   aggregate) reads each stored row in turn before the result is formed.
// Sort runs bubble passes over the rows, repeated until a pass makes no
//   swap. The column memory has one write port and one registered read port.
// One request at a time; a new one is taken once the result is registered.
// Reset (rst, synchronous) empties the column and clears key mode; memory
//   contents are not cleared and rows beyond the count are never read.
module integer_column_store_engine #(
  parameter int MAX_ROWS = icse_pkg::MaxRowsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // row_index[9:0], operand_value[41:10], compare_op[44:42], sort_order[46:45]
  input  logic [icse_pkg::InDataW-1:0]  s_axis_tdata,
  // kind[2:0]
  input  logic [icse_pkg::KindW-1:0]    s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // match[0], row_total[11:1], minimum[43:12], maximum[75:44], total[107:76]
  output logic [icse_pkg::OutDataW-1:0] m_axis_tdata,
  // status[2:0]
  output logic [icse_pkg::StatW-1:0]    m_axis_tuser,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [icse_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  icse_pkg::icse_cmd_t  cmd;
  icse_pkg::icse_stat_t stat;
  logic                 unique_key_mode;

  // Key mode register: written on the access phase of an APB write.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      unique_key_mode <= 1'b0;
    end else if (psel && penable && pwrite && paddr == icse_pkg::RegUniqueKey) begin
      unique_key_mode <= pwdata[0];
    end
  end
  assign prdata = (paddr == icse_pkg::RegUniqueKey) ? {31'b0, unique_key_mode} : 32'b0;

  icse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  icse_dp #(
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_data    (s_axis_tdata),
    .in_kind    (s_axis_tuser),
    .uniq       (unique_key_mode),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_status (m_axis_tuser)
  );

endmodule

FILE: src/icse_ctrl.sv
// ----------------------------------------------------------------------------
// icse_ctrl: sequencer for the column store engine
// Steps each request through scans, writes and sort passes of the datapath.
// ----------------------------------------------------------------------------
module icse_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  icse_pkg::icse_stat_t  stat,
  output icse_pkg::icse_cmd_t   cmd
);

  icse_pkg::state_t              state, state_next;
  logic [icse_pkg::StatW-1:0]    res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= icse_pkg::S_IDLE;
      res   <= icse_pkg::StOk;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    res_next   = res;
    in_ready   = 1'b0;
    cmd.op     = icse_pkg::DP_IDLE;
    cmd.res    = res;
    case (state)
      icse_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = icse_pkg::DP_LOAD;
          state_next = icse_pkg::S_DISPATCH;
        end
      end
      icse_pkg::S_DISPATCH: begin
        res_next   = icse_pkg::StOk;
        state_next = icse_pkg::S_RESULT;
        case (stat.kind)
          icse_pkg::KindAppend: begin
            if (stat.full) res_next = icse_pkg::StFull;
            else if (stat.uniq && !stat.empty) state_next = icse_pkg::S_SCAN_RD;
            else state_next = icse_pkg::S_APPEND;
          end
          icse_pkg::KindUpdate: begin
            if (!stat.row_ok) res_next = icse_pkg::StNoRow;
            else if (stat.uniq) state_next = icse_pkg::S_SCAN_RD;
            else state_next = icse_pkg::S_UPDATE;
          end
          icse_pkg::KindTest: begin
            if (!stat.row_ok) res_next = icse_pkg::StNoRow;
            else state_next = icse_pkg::S_ROW_RD;
          end
          icse_pkg::KindAggr: begin
            if (!stat.empty) state_next = icse_pkg::S_SCAN_RD;
          end
          icse_pkg::KindSort: begin
            if (!stat.ord_ok) res_next = icse_pkg::StBadOp;
            else if (!stat.fewer_two) state_next = icse_pkg::S_SORT_START;
          end
          default: res_next = icse_pkg::StBadOp;
        endcase
      end
      icse_pkg::S_SCAN_RD: begin
        cmd.op     = icse_pkg::DP_READ_IDX;
        state_next = icse_pkg::S_SCAN_USE;
      end
      icse_pkg::S_SCAN_USE: begin
        cmd.op     = icse_pkg::DP_SCAN_STEP;
        state_next = icse_pkg::S_SCAN_CHK;
      end
      icse_pkg::S_SCAN_CHK: begin
        if (!stat.idx_done) begin
          state_next = icse_pkg::S_SCAN_RD;
        end else if (stat.kind == icse_pkg::KindAggr) begin
          state_next = icse_pkg::S_RESULT;
        end else if (stat.found) begin
          res_next   = icse_pkg::StDup;
          state_next = icse_pkg::S_RESULT;
        end else if (stat.kind == icse_pkg::KindAppend) begin
          state_next = icse_pkg::S_APPEND;
        end else begin
          state_next = icse_pkg::S_UPDATE;
        end
      end
      icse_pkg::S_APPEND: begin
        cmd.op     = icse_pkg::DP_APPEND;
        state_next = icse_pkg::S_RESULT;
      end
      icse_pkg::S_UPDATE: begin
        cmd.op     = icse_pkg::DP_UPDATE;
        state_next = icse_pkg::S_RESULT;
      end
      icse_pkg::S_ROW_RD: begin
        cmd.op     = icse_pkg::DP_READ_ROW;
        state_next = icse_pkg::S_TEST;
      end
      icse_pkg::S_TEST: begin
        cmd.op     = icse_pkg::DP_TEST;
        res_next   = stat.op_ok ? icse_pkg::StOk : icse_pkg::StBadOp;
        state_next = icse_pkg::S_RESULT;
      end
      icse_pkg::S_SORT_START: begin
        cmd.op     = icse_pkg::DP_SORT_INIT;
        state_next = icse_pkg::S_SORT_RD0;
      end
      icse_pkg::S_SORT_RD0: begin
        cmd.op     = icse_pkg::DP_READ_IDX;
        state_next = icse_pkg::S_SORT_LOAD;
      end
      icse_pkg::S_SORT_LOAD: begin
        cmd.op     = icse_pkg::DP_SORT_FIRST;
        state_next = icse_pkg::S_SORT_RD;
      end
      icse_pkg::S_SORT_RD: begin
        cmd.op     = icse_pkg::DP_READ_IDX;
        state_next = icse_pkg::S_SORT_STEP;
      end
      icse_pkg::S_SORT_STEP: begin
        cmd.op     = icse_pkg::DP_SORT_STEP;
        state_next = icse_pkg::S_SORT_CHK;
      end
      icse_pkg::S_SORT_CHK: begin
        state_next = stat.idx_done ? icse_pkg::S_SORT_LAST : icse_pkg::S_SORT_RD;
      end
      icse_pkg::S_SORT_LAST: begin
        cmd.op     = icse_pkg::DP_SORT_LAST;
        state_next = stat.swapped ? icse_pkg::S_SORT_START : icse_pkg::S_RESULT;
      end
      icse_pkg::S_RESULT: begin
        if (stat.out_free) begin
          cmd.op     = icse_pkg::DP_RESULT;
          state_next = icse_pkg::S_IDLE;
        end
      end
      default: state_next = icse_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: src/icse_dp.sv
// ----------------------------------------------------------------------------
// icse_dp: datapath of the column store engine
// Column memory, row count, scan and sort registers, and the result register.
// ----------------------------------------------------------------------------
module icse_dp #(
  parameter int MAX_ROWS = icse_pkg::MaxRowsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  icse_pkg::icse_cmd_t           cmd,
  input  logic [icse_pkg::InDataW-1:0]  in_data,
  input  logic [icse_pkg::KindW-1:0]    in_kind,
  input  logic                          uniq,
  output icse_pkg::icse_stat_t          stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [icse_pkg::OutDataW-1:0] out_data,
  output logic [icse_pkg::StatW-1:0]    out_status
);

  localparam int AW   = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
  localparam int CW   = $clog2(MAX_ROWS + 1);
  localparam int CMPW = (CW > icse_pkg::RowW) ? CW : icse_pkg::RowW;

  logic signed [31:0] mem [MAX_ROWS];
  logic signed [31:0] rd_data;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic signed [31:0] wr_data;
  logic               wr_en;

  // latched request
  logic [icse_pkg::KindW-1:0] kind;
  logic [icse_pkg::RowW-1:0]  row;
  logic signed [31:0]         val;
  logic [icse_pkg::OpW-1:0]   op;
  logic [icse_pkg::OrdW-1:0]  ord;

  logic [CW-1:0]      count, idx, idx_m1, count_m1;
  logic signed [31:0] carry, mn, mx, sum;
  logic               found, swapped, match;
  logic               desc, out_of_order, test_hit;

  assign idx_m1   = idx - CW'(1);
  assign count_m1 = count - CW'(1);
  assign desc     = (ord == icse_pkg::OrdDesc);
  assign out_of_order = desc ? (carry < rd_data) : (carry > rd_data);

  always_comb begin
    case (op)
      icse_pkg::OpEq: test_hit = (rd_data == val);
      icse_pkg::OpGt: test_hit = (rd_data > val);
      icse_pkg::OpGe: test_hit = (rd_data >= val);
      icse_pkg::OpLt: test_hit = (rd_data < val);
      icse_pkg::OpLe: test_hit = (rd_data <= val);
      icse_pkg::OpNe: test_hit = (rd_data != val);
      default:        test_hit = 1'b0;
    endcase
  end

  always_comb begin
    rd_addr = (cmd.op == icse_pkg::DP_READ_ROW) ? AW'(row) : idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_m1[AW-1:0];
    wr_data = val;
    case (cmd.op)
      icse_pkg::DP_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = count[AW-1:0];
      end
      icse_pkg::DP_UPDATE: begin
        wr_en   = 1'b1;
        wr_addr = AW'(row);
      end
      icse_pkg::DP_SORT_STEP: begin
        wr_en   = 1'b1;
        wr_data = out_of_order ? rd_data : carry;
      end
      icse_pkg::DP_SORT_LAST: begin
        wr_en   = 1'b1;
        wr_addr = count_m1[AW-1:0];
        wr_data = carry;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == icse_pkg::DP_APPEND) count <= count + CW'(1);
      if (cmd.op == icse_pkg::DP_RESULT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      icse_pkg::DP_LOAD: begin
        kind    <= in_kind;
        row     <= in_data[9:0];
        val     <= in_data[41:10];
        op      <= in_data[44:42];
        ord     <= in_data[46:45];
        idx     <= '0;
        found   <= 1'b0;
        match   <= 1'b0;
        mn      <= 32'sh7FFFFFFF;
        mx      <= 32'sh80000000;
        sum     <= '0;
      end
      icse_pkg::DP_SCAN_STEP: begin
        if (rd_data == val) found <= 1'b1;
        if (rd_data < mn) mn <= rd_data;
        if (rd_data > mx) mx <= rd_data;
        sum <= sum + rd_data;
        idx <= idx + CW'(1);
      end
      icse_pkg::DP_TEST: match <= test_hit;
      icse_pkg::DP_SORT_INIT: begin
        idx     <= '0;
        swapped <= 1'b0;
      end
      icse_pkg::DP_SORT_FIRST: begin
        carry <= rd_data;
        idx   <= CW'(1);
      end
      icse_pkg::DP_SORT_STEP: begin
        if (out_of_order) swapped <= 1'b1;
        else carry <= rd_data;
        idx <= idx + CW'(1);
      end
      icse_pkg::DP_RESULT: begin
        out_status <= cmd.res;
        out_data[0]      <= (kind == icse_pkg::KindTest) ? match : 1'b0;
        out_data[11:1]   <= icse_pkg::TotalW'(count);
        out_data[43:12]  <= (kind == icse_pkg::KindAggr) ? mn : '0;
        out_data[75:44]  <= (kind == icse_pkg::KindAggr) ? mx : '0;
        out_data[107:76] <= (kind == icse_pkg::KindAggr) ? sum : '0;
        out_data[111:108] <= '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.kind      = kind;
    stat.uniq      = uniq;
    stat.full      = (count == CW'(MAX_ROWS));
    stat.empty     = (count == '0);
    stat.fewer_two = (count < CW'(2));
    stat.row_ok    = (CMPW'(row) < CMPW'(count));
    stat.op_ok     = (op <= icse_pkg::OpNe);
    stat.ord_ok    = (ord == icse_pkg::OrdAsc) || (ord == icse_pkg::OrdDesc);
    stat.idx_done  = (idx == count);
    stat.found     = found;
    stat.swapped   = swapped;
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the integer column store engine
// Walks a directed table, then random requests in bursts under result
// stalls, with key mode changed between phases and a final fill to full.
// Every result is checked against a local column predictor or a typed outcome.
// ----------------------------------------------------------------------------
module tb;

  localparam int NumRows   = 1024;
  localparam int StallMax  = 100000;
  localparam int SortLimit = 48;

  typedef struct packed {
    logic [icse_pkg::StatW-1:0]  status;
    logic                        match;
    logic [icse_pkg::TotalW-1:0] row_total;
    logic [icse_pkg::ValW-1:0]   minimum;
    logic [icse_pkg::ValW-1:0]   maximum;
    logic [icse_pkg::ValW-1:0]   total;
  } outcome_t;

  typedef struct packed {
    logic                       wr_mode;   // write key mode before this request
    logic                       mode_val;
    logic [icse_pkg::KindW-1:0] kind;
    logic [icse_pkg::RowW-1:0]  row;
    logic [icse_pkg::ValW-1:0]  val;
    logic [icse_pkg::OpW-1:0]   op;
    logic [icse_pkg::OrdW-1:0]  ord;
    logic                       typed;     // use the typed outcome below
    outcome_t                   want;
  } dir_row_t;

  localparam logic [icse_pkg::KindW-1:0] KindBad5 = 3'd5;
  localparam logic [icse_pkg::KindW-1:0] KindBad7 = 3'd7;
  localparam logic [icse_pkg::OpW-1:0]   OpBad6   = 3'd6;
  localparam logic [icse_pkg::OrdW-1:0]  OrdBad2  = 2'd2;
  localparam logic [icse_pkg::OrdW-1:0]  OrdBad3  = 2'd3;
  localparam logic [icse_pkg::ValW-1:0]  IntMin   = 32'h8000_0000;
  localparam logic [icse_pkg::ValW-1:0]  IntMax   = 32'h7FFF_FFFF;

  logic                          clk;
  logic                          rst;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [icse_pkg::InDataW-1:0]  s_axis_tdata;
  logic [icse_pkg::KindW-1:0]    s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [icse_pkg::OutDataW-1:0] m_axis_tdata;
  logic [icse_pkg::StatW-1:0]    m_axis_tuser;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [icse_pkg::AddrW-1:0]    paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  integer_column_store_engine u_dut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // predictor state: the column, its row count and the key mode
  logic [icse_pkg::ValW-1:0] col_vals [NumRows];
  int              col_rows;
  logic            key_mode;
  outcome_t        pending_results [$];
  int              fail_count;
  int              idle_cycles;
  int              burst_left;
  dir_row_t        dir_tab [24];

  function automatic bit col_holds(logic [icse_pkg::ValW-1:0] v);
    for (int i = 0; i < col_rows; i++)
      if (col_vals[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  // Apply one request to the column and return the outcome it gives.
  function automatic outcome_t column_step(logic [icse_pkg::KindW-1:0] kind,
                                           logic [icse_pkg::RowW-1:0] row,
                                           logic [icse_pkg::ValW-1:0] val,
                                           logic [icse_pkg::OpW-1:0] op,
                                           logic [icse_pkg::OrdW-1:0] ord);
    outcome_t r;
    logic signed [icse_pkg::ValW-1:0] a, b, mn, mx;
    logic [icse_pkg::ValW-1:0] t;
    int j;
    r = '0;
    r.status = icse_pkg::StOk;
    a = col_vals[row];
    b = val;
    case (kind)
      icse_pkg::KindAppend: begin
        if (col_rows >= NumRows) r.status = icse_pkg::StFull;
        else if (key_mode && col_holds(val)) r.status = icse_pkg::StDup;
        else begin
          col_vals[col_rows] = val;
          col_rows++;
        end
      end
      icse_pkg::KindUpdate: begin
        if (int'(row) >= col_rows) r.status = icse_pkg::StNoRow;
        else if (key_mode && col_holds(val)) r.status = icse_pkg::StDup;
        else col_vals[row] = val;
      end
      icse_pkg::KindTest: begin
        if (int'(row) >= col_rows) r.status = icse_pkg::StNoRow;
        else begin
          case (op)
            icse_pkg::OpEq: r.match = (a == b);
            icse_pkg::OpGt: r.match = (a > b);
            icse_pkg::OpGe: r.match = (a >= b);
            icse_pkg::OpLt: r.match = (a < b);
            icse_pkg::OpLe: r.match = (a <= b);
            icse_pkg::OpNe: r.match = (a != b);
            default: r.status = icse_pkg::StBadOp;
          endcase
        end
      end
      icse_pkg::KindAggr: begin
        mn = IntMax;
        mx = IntMin;
        for (int i = 0; i < col_rows; i++) begin
          a = col_vals[i];
          if (a < mn) mn = a;
          if (a > mx) mx = a;
          r.total += col_vals[i];
        end
        r.minimum = mn;
        r.maximum = mx;
      end
      icse_pkg::KindSort: begin
        if (ord != icse_pkg::OrdAsc && ord != icse_pkg::OrdDesc) r.status = icse_pkg::StBadOp;
        else begin
          // equal values cannot be told apart, so any correct sort agrees
          for (int i = 1; i < col_rows; i++) begin
            t = col_vals[i];
            j = i;
            while (j > 0 && ((ord == icse_pkg::OrdAsc)
                             ? ($signed(col_vals[j-1]) > $signed(t))
                             : ($signed(col_vals[j-1]) < $signed(t)))) begin
              col_vals[j] = col_vals[j-1];
              j--;
            end
            col_vals[j] = t;
          end
        end
      end
      default: r.status = icse_pkg::StBadOp;
    endcase
    r.row_total = col_rows[icse_pkg::TotalW-1:0];
    return r;
  endfunction

  // Hold one request on the bus until it is accepted; tvalid stays high.
  task automatic send_request(logic [icse_pkg::KindW-1:0] kind,
                              logic [icse_pkg::RowW-1:0] row,
                              logic [icse_pkg::ValW-1:0] val,
                              logic [icse_pkg::OpW-1:0] op,
                              logic [icse_pkg::OrdW-1:0] ord, bit typed, outcome_t want);
    outcome_t r;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, ord, op, val, row};
    r = column_step(kind, row, val, op, ord);
    pending_results.insert(pending_results.size(), typed ? want : r);
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Two-phase register write; the block is idle here.
  task automatic write_key_mode(logic v);
    drain_results();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= icse_pkg::RegUniqueKey;
    pwdata  <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    key_mode = v;
    @(posedge clk);
  endtask

  // Random request shaped to stay mostly on existing rows and often on stored values.
  task automatic random_request();
    logic [icse_pkg::KindW-1:0] kind;
    logic [icse_pkg::RowW-1:0]  row;
    logic [icse_pkg::ValW-1:0]  val;
    int                         pick;
    pick = $urandom_range(0, 99);
    if (pick < 22)      kind = icse_pkg::KindAppend;
    else if (pick < 40) kind = icse_pkg::KindUpdate;
    else if (pick < 75) kind = icse_pkg::KindTest;
    else if (pick < 87) kind = icse_pkg::KindAggr;
    else if (pick < 94) kind = icse_pkg::KindSort;
    else                kind = 3'($urandom_range(5, 7));
    // keep the column small so that sorting stays short
    if (kind == icse_pkg::KindAppend && col_rows >= SortLimit) kind = icse_pkg::KindTest;
    if (kind == icse_pkg::KindSort && col_rows > SortLimit) kind = icse_pkg::KindAggr;
    if (col_rows > 0 && $urandom_range(0, 9) != 0)
      row = icse_pkg::RowW'($urandom_range(0, col_rows - 1));
    else
      row = icse_pkg::RowW'($urandom);
    case ($urandom_range(0, 9))
      0:       val = IntMin;
      1:       val = IntMax;
      2, 3, 4: val = (col_rows > 0) ? col_vals[$urandom_range(0, col_rows - 1)] : 32'd0;
      5:       val = 32'($signed($urandom_range(0, 15)) - 8);
      default: val = $urandom;
    endcase
    send_request(kind, row, val, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                 1'b0, '0);
  endtask

  // Check results in order and count stalled cycles.
  always @(posedge clk) begin
    outcome_t got, want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[0], m_axis_tdata[11:1], m_axis_tdata[43:12],
               m_axis_tdata[75:44], m_axis_tdata[107:76]};
        if (pending_results.size() == 0) begin
          $error("result with none expected: status %0d", got.status);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.match !== want.match) begin
            $error("match: expected %0d, got %0d", want.match, got.match);
            fail_count++;
          end
          if (got.row_total !== want.row_total) begin
            $error("row_total: expected %0d, got %0d", want.row_total, got.row_total);
            fail_count++;
          end
          if (got.minimum !== want.minimum) begin
            $error("minimum: expected %h, got %h", want.minimum, got.minimum);
            fail_count++;
          end
          if (got.maximum !== want.maximum) begin
            $error("maximum: expected %h, got %h", want.maximum, got.maximum);
            fail_count++;
          end
          if (got.total !== want.total) begin
            $error("total: expected %h, got %h", want.total, got.total);
            fail_count++;
          end
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallMax) begin
        $display("Regression FAIL");
        $finish;
      end
      // random stalls: ready is low only when both random draws say so
      m_axis_tready <= ((($urandom_range(0, 255) & 8'h80) != 0) ||
                        ($urandom_range(0, 3) != 0));
    end
  end

  initial begin
    outcome_t empty_out, bad_out, norow0, norow4;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    col_rows      = 0;
    key_mode      = 1'b0;
    fail_count    = 0;
    burst_left    = 4;

    // outcomes read straight off the definition
    empty_out = '{icse_pkg::StOk, 1'b0, 11'd0, IntMax, IntMin, 32'd0};
    bad_out   = '{icse_pkg::StBadOp, 1'b0, 11'd0, 32'd0, 32'd0, 32'd0};
    norow0    = '{icse_pkg::StNoRow, 1'b0, 11'd0, 32'd0, 32'd0, 32'd0};
    norow4    = '{icse_pkg::StNoRow, 1'b0, 11'd4, 32'd0, 32'd0, 32'd0};
    dir_tab[0]  = '{0, 0, icse_pkg::KindAggr, 10'd0, 32'd0, icse_pkg::OpEq,
                    icse_pkg::OrdAsc, 1, empty_out};
    dir_tab[1]  = '{0, 0, icse_pkg::KindTest, 10'd0, 32'd0, icse_pkg::OpEq,
                    icse_pkg::OrdAsc, 1, norow0};
    dir_tab[2]  = '{0, 0, icse_pkg::KindUpdate, 10'd1023, IntMax, icse_pkg::OpEq,
                    icse_pkg::OrdAsc, 1, norow0};
    dir_tab[3]  = '{0, 0, KindBad5, 10'd0, 32'd0, icse_pkg::OpEq,
                    icse_pkg::OrdAsc, 1, bad_out};
    dir_tab[4]  = '{0, 0, KindBad7, 10'd1023, IntMin, OpBad6, OrdBad3, 1, bad_out};
    dir_tab[5]  = '{0, 0, icse_pkg::KindSort, 10'd0, 32'd0, icse_pkg::OpEq,
                    OrdBad2, 1, bad_out};
    dir_tab[6]  = '{0, 0, icse_pkg::KindSort, 10'd0, 32'd0, icse_pkg::OpEq,
                    OrdBad3, 1, bad_out};
    dir_tab[7]  = '{0, 0, icse_pkg::KindAppend, 10'd0, IntMin, icse_pkg::OpEq,
                    icse_pkg::OrdAsc, 1,
                    '{icse_pkg::StOk, 1'b0, 11'd1, 32'd0, 32'd0, 32'd0}};
    dir_tab[8]  = '{0, 0, icse_pkg::KindAppend, 10'd0, IntMax, icse_pkg::OpEq,
                    icse_pkg::OrdAsc, 1,
                    '{icse_pkg::StOk, 1'b0, 11'd2, 32'd0, 32'd0, 32'd0}};
    dir_tab[9]  = '{0, 0, icse_pkg::KindAppend, 10'd0, 32'd0, icse_pkg::OpEq,
                    icse_pkg::OrdAsc, 1,
                    '{icse_pkg::StOk, 1'b0, 11'd3, 32'd0, 32'd0, 32'd0}};
    dir_tab[10] = '{0, 0, icse_pkg::KindAppend, 10'd0, 32'hFFFF_FFFF, icse_pkg::OpEq,
                    icse_pkg::OrdAsc, 1,
                    '{icse_pkg::StOk, 1'b0, 11'd4, 32'd0, 32'd0, 32'd0}};
    dir_tab[11] = '{0, 0, icse_pkg::KindAggr, 10'd0, 32'd0, icse_pkg::OpEq,
                    icse_pkg::OrdAsc, 1,
                    '{icse_pkg::StOk, 1'b0, 11'd4, IntMin, IntMax, 32'hFFFF_FFFE}};
    dir_tab[12] = '{0, 0, icse_pkg::KindTest, 10'd0, IntMax, icse_pkg::OpEq,
                    icse_pkg::OrdAsc, 0, '0};
    dir_tab[13] = '{0, 0, icse_pkg::KindTest, 10'd0, IntMax, icse_pkg::OpGt,
                    icse_pkg::OrdAsc, 0, '0};
    dir_tab[14] = '{0, 0, icse_pkg::KindTest, 10'd1, IntMax, icse_pkg::OpGe,
                    icse_pkg::OrdAsc, 0, '0};
    dir_tab[15] = '{0, 0, icse_pkg::KindTest, 10'd1, IntMax, icse_pkg::OpLt,
                    icse_pkg::OrdAsc, 0, '0};
    dir_tab[16] = '{0, 0, icse_pkg::KindTest, 10'd2, 32'd0, icse_pkg::OpLe,
                    icse_pkg::OrdAsc, 0, '0};
    dir_tab[17] = '{0, 0, icse_pkg::KindTest, 10'd3, IntMin, icse_pkg::OpNe,
                    icse_pkg::OrdAsc, 0, '0};
    dir_tab[18] = '{0, 0, icse_pkg::KindTest, 10'd3, 32'd0, OpBad6, icse_pkg::OrdAsc, 1,
                    '{icse_pkg::StBadOp, 1'b0, 11'd4, 32'd0, 32'd0, 32'd0}};
    dir_tab[19] = '{0, 0, icse_pkg::KindTest, 10'd4, 32'd0, icse_pkg::OpEq,
                    icse_pkg::OrdAsc, 1, norow4};
    dir_tab[20] = '{0, 0, icse_pkg::KindSort, 10'd0, 32'd0, icse_pkg::OpEq,
                    icse_pkg::OrdAsc, 0, '0};
    dir_tab[21] = '{0, 0, icse_pkg::KindSort, 10'd0, 32'd0, icse_pkg::OpEq,
                    icse_pkg::OrdDesc, 0, '0};
    // unique keys: a stored value and an update to a row's own value are rejected
    dir_tab[22] = '{1, 1, icse_pkg::KindAppend, 10'd0, 32'd0, icse_pkg::OpEq,
                    icse_pkg::OrdAsc, 1,
                    '{icse_pkg::StDup, 1'b0, 11'd4, 32'd0, 32'd0, 32'd0}};
    dir_tab[23] = '{0, 0, icse_pkg::KindUpdate, 10'd2, 32'hFFFF_FFFF, icse_pkg::OpEq,
                    icse_pkg::OrdAsc, 0, '0};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr_mode) write_key_mode(dir_tab[i].mode_val);
      send_request(dir_tab[i].kind, dir_tab[i].row, dir_tab[i].val, dir_tab[i].op,
                   dir_tab[i].ord, dir_tab[i].typed, dir_tab[i].want);
    end

    // random phases under alternating key modes
    write_key_mode(1'b0);
    repeat (200) random_request();
    write_key_mode(1'b1);
    repeat (200) random_request();
    write_key_mode(1'b0);
    repeat (180) random_request();

    // fill the column, then hit the full case in both modes
    while (col_rows < NumRows)
      send_request(icse_pkg::KindAppend, 10'd0, 32'(col_rows * 4096 + 7), icse_pkg::OpEq,
                   icse_pkg::OrdAsc, 1'b0, '0);
    send_request(icse_pkg::KindAppend, 10'd0, 32'd1, icse_pkg::OpEq, icse_pkg::OrdAsc,
                 1'b0, '0);
    send_request(icse_pkg::KindAggr, 10'd0, 32'd0, icse_pkg::OpEq, icse_pkg::OrdAsc,
                 1'b0, '0);
    send_request(icse_pkg::KindTest, 10'd1023, IntMin, icse_pkg::OpGt, icse_pkg::OrdAsc,
                 1'b0, '0);
    write_key_mode(1'b1);
    send_request(icse_pkg::KindAppend, 10'd0, 32'd7, icse_pkg::OpEq, icse_pkg::OrdAsc,
                 1'b0, '0);
    send_request(icse_pkg::KindUpdate, 10'd1023, 32'd7, icse_pkg::OpEq, icse_pkg::OrdAsc,
                 1'b0, '0);
    send_request(icse_pkg::KindUpdate, 10'd1023, IntMin + 32'd3, icse_pkg::OpEq,
                 icse_pkg::OrdAsc, 1'b0, '0);
    send_request(icse_pkg::KindAggr, 10'd0, 32'd0, icse_pkg::OpEq, icse_pkg::OrdAsc,
                 1'b0, '0);

    drain_results();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
